### hw/rtl/jpeg_frame_header_scanner_unit_defines.svh
// Assertion macros shared by the frame header scanner RTL.
`ifndef JPEG_FRAME_HEADER_SCANNER_UNIT_DEFINES_SVH
`define JPEG_FRAME_HEADER_SCANNER_UNIT_DEFINES_SVH

// Checked at every rising edge outside reset.
`define JFHS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define JFHS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/jfhs_pkg.sv
// Package: marker codes, frame limits and the verdict record of the scanner.
package jfhs_pkg;

   localparam logic [7:0] MARK_PREFIX = 8'hFF;
   localparam logic [7:0] MARK_SOI    = 8'hD8;
   localparam logic [7:0] MARK_EOI    = 8'hD9;
   localparam logic [7:0] MARK_SOS    = 8'hDA;
   localparam logic [7:0] MARK_RST0   = 8'hD0;
   localparam logic [7:0] MARK_RST7   = 8'hD7;
   localparam logic [7:0] MARK_TEM    = 8'h01;

   localparam logic [15:0] SEG_LEN_MIN   = 16'd2;
   localparam logic [15:0] FRAME_LEN_MIN = 16'd8;
   localparam logic [7:0]  COMP_MAX      = 8'd4;
   localparam logic [7:0]  PRECISION_RGB = 8'd8;

   localparam logic [63:0] MAX_IMAGE_BYTES_RESET = 64'd268435456;

   typedef struct packed {
      logic        valid;
      logic        found;
      logic        progressive;
      logic [15:0] width;
      logic [15:0] height;
      logic [7:0]  precision;
      logic [2:0]  components;
   } verdict_type;

   function automatic logic is_frame_code(input logic [7:0] m);
      return (m >= 8'hC0 && m <= 8'hC3) || (m >= 8'hC5 && m <= 8'hC7) ||
             (m >= 8'hC9 && m <= 8'hCB) || (m >= 8'hCD && m <= 8'hCF);
   endfunction

   function automatic logic is_progressive_code(input logic [7:0] m);
      return m == 8'hC2 || m == 8'hC6 || m == 8'hCA || m == 8'hCE;
   endfunction

endpackage

### hw/rtl/jfhs_parser.sv
// Marker and segment parser: per-byte state update and verdict decision.
module jfhs_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic                  step,
   input  logic [7:0]            data_byte,
   input  logic                  last_byte,
   output jfhs_pkg::verdict_type verdict,
   output logic                  capture,
   output logic [15:0]           held_width,
   output logic [15:0]           held_height
);

   typedef enum logic [3:0] {
      PH_START_FF,
      PH_START_D8,
      PH_PREFIX,
      PH_CODE,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_SKIP,
      PH_FRAME,
      PH_TAIL
   } phase_type;

   typedef enum logic [1:0] {
      OUTCOME_ON,
      OUTCOME_FAIL,
      OUTCOME_FOUND
   } outcome_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] skip_ff, skip_in;
   logic [7:0]  len_high_ff, len_high_in;
   logic [7:0]  marker_ff, marker_in;
   logic [2:0]  idx_ff, idx_in;
   logic [7:0]  prec_ff, prec_in;
   logic [15:0] height_ff, height_in;
   logic [15:0] width_ff, width_in;
   logic [2:0]  comp_ff, comp_in;
   logic        verdict_given_ff;

   outcome_type outcome;
   logic        capture_c;
   logic        result;
   logic        found;
   logic [15:0] len_word;
   logic [15:0] skip_dec;
   logic [15:0] three_b;

   assign len_word = {len_high_ff, data_byte};
   assign skip_dec = skip_ff - 16'd1;
   assign three_b  = {7'd0, data_byte, 1'b0} + {8'd0, data_byte};

   always_comb begin
      phase_in    = phase_ff;
      skip_in     = skip_ff;
      len_high_in = len_high_ff;
      marker_in   = marker_ff;
      idx_in      = idx_ff;
      prec_in     = prec_ff;
      height_in   = height_ff;
      width_in    = width_ff;
      comp_in     = comp_ff;
      outcome     = OUTCOME_ON;
      capture_c   = 1'b0;
      case (phase_ff)
         PH_START_FF: begin
            if (data_byte != jfhs_pkg::MARK_PREFIX) outcome = OUTCOME_FAIL;
            else phase_in = PH_START_D8;
         end
         PH_START_D8: begin
            if (data_byte != jfhs_pkg::MARK_SOI) outcome = OUTCOME_FAIL;
            else phase_in = PH_PREFIX;
         end
         PH_PREFIX: begin
            if (data_byte != jfhs_pkg::MARK_PREFIX) outcome = OUTCOME_FAIL;
            else phase_in = PH_CODE;
         end
         PH_CODE: begin
            if (data_byte == jfhs_pkg::MARK_PREFIX) begin
               phase_in = PH_CODE;
            end else if (data_byte == jfhs_pkg::MARK_EOI ||
                         data_byte == jfhs_pkg::MARK_SOS) begin
               outcome = OUTCOME_FAIL;
            end else if ((data_byte >= jfhs_pkg::MARK_RST0 &&
                          data_byte <= jfhs_pkg::MARK_RST7) ||
                         data_byte == jfhs_pkg::MARK_TEM) begin
               phase_in = PH_PREFIX;
            end else begin
               marker_in = data_byte;
               phase_in  = PH_LEN_HI;
            end
         end
         PH_LEN_HI: begin
            len_high_in = data_byte;
            phase_in    = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            if (len_word < jfhs_pkg::SEG_LEN_MIN) begin
               outcome = OUTCOME_FAIL;
            end else begin
               skip_in = len_word - jfhs_pkg::SEG_LEN_MIN;
               if (jfhs_pkg::is_frame_code(marker_ff)) begin
                  if (len_word < jfhs_pkg::FRAME_LEN_MIN) begin
                     outcome = OUTCOME_FAIL;
                  end else begin
                     idx_in   = 3'd0;
                     phase_in = PH_FRAME;
                  end
               end else begin
                  phase_in = (len_word == jfhs_pkg::SEG_LEN_MIN) ? PH_PREFIX : PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == 16'd0) phase_in = PH_PREFIX;
         end
         PH_FRAME: begin
            skip_in = skip_dec;
            idx_in  = idx_ff + 3'd1;
            case (idx_ff)
               3'd0: prec_in = data_byte;
               3'd1, 3'd2: height_in = {height_ff[7:0], data_byte};
               3'd3, 3'd4: width_in = {width_ff[7:0], data_byte};
               default: begin
                  if (width_ff == 16'd0 || height_ff == 16'd0 || data_byte == 8'd0 ||
                      data_byte > jfhs_pkg::COMP_MAX) begin
                     outcome = OUTCOME_FAIL;
                  end else if (skip_dec != three_b) begin
                     outcome = OUTCOME_FAIL;
                  end else begin
                     comp_in   = data_byte[2:0];
                     phase_in  = PH_TAIL;
                     capture_c = 1'b1;
                  end
               end
            endcase
         end
         PH_TAIL: begin
            skip_in = skip_dec;
            if (skip_dec == 16'd0) outcome = OUTCOME_FOUND;
         end
         default: outcome = OUTCOME_FAIL;
      endcase
   end

   assign result  = !verdict_given_ff && (outcome != OUTCOME_ON || last_byte);
   assign found   = outcome == OUTCOME_FOUND;
   assign capture = step && !verdict_given_ff && capture_c;

   always_comb begin
      verdict.valid       = in_valid && result;
      verdict.found       = found;
      verdict.progressive = found && jfhs_pkg::is_progressive_code(marker_ff);
      verdict.width       = found ? width_ff : 16'd0;
      verdict.height      = found ? height_ff : 16'd0;
      verdict.precision   = found ? prec_ff : 8'd0;
      verdict.components  = found ? comp_ff : 3'd0;
   end

   assign held_width  = width_ff;
   assign held_height = height_ff;

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         phase_ff         <= PH_START_FF;
         skip_ff          <= 16'd0;
         len_high_ff      <= 8'd0;
         marker_ff        <= 8'd0;
         idx_ff           <= 3'd0;
         prec_ff          <= 8'd0;
         height_ff        <= 16'd0;
         width_ff         <= 16'd0;
         comp_ff          <= 3'd0;
         verdict_given_ff <= 1'b0;
      end else if (step && !verdict_given_ff) begin
         phase_ff         <= phase_in;
         skip_ff          <= skip_in;
         len_high_ff      <= len_high_in;
         marker_ff        <= marker_in;
         idx_ff           <= idx_in;
         prec_ff          <= prec_in;
         height_ff        <= height_in;
         width_ff         <= width_in;
         comp_ff          <= comp_in;
         verdict_given_ff <= result;
      end
   end

endmodule

### hw/rtl/jfhs_budget.sv
// Decoded image size check: registered pixel count against the byte budget.
module jfhs_budget (
   input  logic        clock,
   input  logic        capture,
   input  logic [15:0] width,
   input  logic [15:0] height,
   input  logic [63:0] max_image_bytes,
   output logic        size_ok
);

   logic [31:0] pixels_ff, pixels_in;

   assign pixels_in = width * height;

   always_ff @(posedge clock) begin
      if (capture) pixels_ff <= pixels_in;
   end

   // pixels * 4 <= max  <=>  pixels <= max / 4
   assign size_ok = (max_image_bytes[63:34] != 30'd0) ||
                    ((max_image_bytes != 64'd0) && (pixels_ff <= max_image_bytes[33:2]));

endmodule

### hw/rtl/jpeg_frame_header_scanner_unit.sv
// Top level of the JPEG frame header scanner.
// Usage:
//   req_ channel carries one file byte per transaction; req_last_byte marks
//   the final byte of a file. rsp_ channel carries one verdict per file:
//   found flag, dimensions, precision, component count, progressive mark and
//   whether the RGBA8 image fits the byte budget. Failure verdicts are all 0.
//   csr_write_enable/csr_write_data load the 64-bit byte budget; write only
//   while no file is in flight.
// Order: an accepted byte waits in the input register; the parser update and
//   its verdict, if any, are registered from there into the rsp_ register.
// Throughput: one byte per cycle while no verdict waits on rsp_stall; the
//   parser update between the input and result registers is combinational.
// Stall: a byte that makes no verdict moves on while a verdict waits on
//   rsp_stall; one that makes a verdict waits in the input register, and
//   req_stall rises only when that register is held.
// Reset: clears parser state and both valid flags; budget returns to
//   268435456. Bytes after a verdict are dropped until the final byte, which
//   rearms the parser.
module jpeg_frame_header_scanner_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic        rsp_progressive,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic [7:0]  rsp_sample_precision,
   output logic [2:0]  rsp_component_count,
   output logic        rsp_fits_budget,
   input  logic        csr_write_enable,
   input  logic [63:0] csr_write_data
);

   `include "jpeg_frame_header_scanner_unit_defines.svh"

   logic [63:0] max_bytes_ff;
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        out_valid_ff;
   logic        out_free;
   logic        step;
   logic        capture;
   logic        size_ok;
   logic        fits;
   logic [15:0] held_width;
   logic [15:0] held_height;
   logic        req_take;

   jfhs_pkg::verdict_type verdict;
   jfhs_pkg::verdict_type out_ff;
   logic                  out_fits_ff;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && (!verdict.valid || out_free);
   assign req_stall = in_valid_ff && !step;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) max_bytes_ff <= jfhs_pkg::MAX_IMAGE_BYTES_RESET;
      else if (csr_write_enable) max_bytes_ff <= csr_write_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   jfhs_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (in_valid_ff),
      .step        (step),
      .data_byte   (in_byte_ff),
      .last_byte   (in_last_ff),
      .verdict     (verdict),
      .capture     (capture),
      .held_width  (held_width),
      .held_height (held_height)
   );

   jfhs_budget u_budget (
      .clock           (clock),
      .capture         (capture),
      .width           (held_width),
      .height          (held_height),
      .max_image_bytes (max_bytes_ff),
      .size_ok         (size_ok)
   );

   assign fits = verdict.found && (verdict.precision == jfhs_pkg::PRECISION_RGB) && size_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= step && verdict.valid;
      end
      if (out_free && step && verdict.valid) begin
         out_ff      <= verdict;
         out_fits_ff <= fits;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_found            = out_ff.found;
   assign rsp_progressive      = out_ff.progressive;
   assign rsp_image_width      = out_ff.width;
   assign rsp_image_height     = out_ff.height;
   assign rsp_sample_precision = out_ff.precision;
   assign rsp_component_count  = out_ff.components;
   assign rsp_fits_budget      = out_fits_ff;

   `JFHS_ASSERT(a_fail_zero, clock, reset,
      (out_valid_ff && !out_ff.found) |-> (out_ff.width == 16'd0 && out_ff.height == 16'd0 &&
         out_ff.precision == 8'd0 && out_ff.components == 3'd0 && !out_ff.progressive &&
         !out_fits_ff),
      "failure verdict with nonzero fields")
   `JFHS_ASSERT(a_found_sane, clock, reset,
      (out_valid_ff && out_ff.found) |-> (out_ff.width != 16'd0 && out_ff.height != 16'd0 &&
         out_ff.components != 3'd0 && out_ff.components <= 3'd4),
      "found verdict with bad frame fields")
   `JFHS_ASSERT(a_fits_found, clock, reset,
      (out_valid_ff && out_fits_ff) |->
         (out_ff.found && out_ff.precision == jfhs_pkg::PRECISION_RGB),
      "budget fit without valid 8-bit frame")
   `JFHS_ASSERT(a_no_overrun, clock, reset,
      (verdict.valid && out_valid_ff && rsp_stall) |-> !step,
      "verdict stepped into a held result register")
   `JFHS_ASSERT_ALWAYS(a_reset_clear, clock,
      reset |=> (!out_valid_ff && !in_valid_ff),
      "valid flags set right after reset")

endmodule

### tb/frame_verdict_check_pkg.sv
// Verdict predictor and scoreboard for the JPEG frame header scanner testbench.
package frame_verdict_check_pkg;
   import jfhs_pkg::*;

   localparam logic [3:0]  SOF_NIBBLE      = 4'hC;
   localparam logic [63:0] BYTES_PER_PIXEL = 64'd4;
   localparam logic [15:0] COMP_SPEC_BYTES = 16'd3;
   localparam int unsigned MAX_REPORTS     = 10;

   typedef enum logic [3:0] {
      SCAN_START_FF, SCAN_START_SOI, SCAN_PREFIX, SCAN_CODE, SCAN_LEN_HI,
      SCAN_LEN_LO, SCAN_SKIP, SCAN_FRAME, SCAN_TAIL
   } scan_phase_type;

   typedef enum {BYTE_MORE, BYTE_FAIL, BYTE_DONE} byte_outcome_type;

   typedef struct packed {
      logic        found;
      logic        progressive;
      logic [15:0] width;
      logic [15:0] height;
      logic [7:0]  precision;
      logic [2:0]  components;
      logic        fits;
   } verdict_record_type;

   // SOF0-15 minus DHT (C4), JPG (C8) and DAC (CC)
   function automatic logic sof_marker(input logic [7:0] m);
      return m[7:4] == SOF_NIBBLE && !(m[1:0] == 2'b00 && m[3:2] != 2'b00);
   endfunction

   function automatic logic progressive_marker(input logic [7:0] m);
      return sof_marker(m) && m[1:0] == 2'b10;
   endfunction

   class verdict_scoreboard;
      logic [63:0]        budget;
      int unsigned        failures;
      verdict_record_type due_verdicts[$];
      scan_phase_type     phase;
      logic [15:0]        remaining;
      logic [7:0]         len_high;
      logic [7:0]         marker;
      logic [3:0]         field_idx;
      logic [7:0]         precision;
      logic [15:0]        height;
      logic [15:0]        width;
      logic [2:0]         comps;
      bit                 settled;

      function new();
         budget = MAX_IMAGE_BYTES_RESET;
         failures = 0;
         rearm();
      endfunction

      function void rearm();
         phase = SCAN_START_FF;
         remaining = '0;
         len_high = '0;
         marker = '0;
         field_idx = '0;
         precision = '0;
         height = '0;
         width = '0;
         comps = '0;
         settled = 1'b0;
      endfunction

      function byte_outcome_type parse_byte(input logic [7:0] b);
         logic [15:0] seg_len;
         case (phase)
            SCAN_START_FF: begin
               if (b != MARK_PREFIX) return BYTE_FAIL;
               phase = SCAN_START_SOI;
            end
            SCAN_START_SOI: begin
               if (b != MARK_SOI) return BYTE_FAIL;
               phase = SCAN_PREFIX;
            end
            SCAN_PREFIX: begin
               if (b != MARK_PREFIX) return BYTE_FAIL;
               phase = SCAN_CODE;
            end
            SCAN_CODE: begin
               if (b == MARK_PREFIX) return BYTE_MORE;
               if (b == MARK_EOI || b == MARK_SOS) return BYTE_FAIL;
               if ((b >= MARK_RST0 && b <= MARK_RST7) || b == MARK_TEM) begin
                  phase = SCAN_PREFIX;
                  return BYTE_MORE;
               end
               marker = b;
               phase = SCAN_LEN_HI;
            end
            SCAN_LEN_HI: begin
               len_high = b;
               phase = SCAN_LEN_LO;
            end
            SCAN_LEN_LO: begin
               seg_len = {len_high, b};
               if (seg_len < SEG_LEN_MIN) return BYTE_FAIL;
               remaining = seg_len - SEG_LEN_MIN;
               if (sof_marker(marker)) begin
                  if (seg_len < FRAME_LEN_MIN) return BYTE_FAIL;
                  field_idx = '0;
                  phase = SCAN_FRAME;
               end else begin
                  phase = (remaining == 16'd0) ? SCAN_PREFIX : SCAN_SKIP;
               end
            end
            SCAN_SKIP: begin
               remaining = remaining - 16'd1;
               if (remaining == 16'd0) phase = SCAN_PREFIX;
            end
            SCAN_FRAME: begin
               remaining = remaining - 16'd1;
               case (field_idx)
                  4'd0: precision = b;
                  4'd1, 4'd2: height = {height[7:0], b};
                  4'd3, 4'd4: width = {width[7:0], b};
                  default: begin
                     if (width == 16'd0 || height == 16'd0 || b == 8'd0 || b > COMP_MAX)
                        return BYTE_FAIL;
                     if (remaining != COMP_SPEC_BYTES * {8'd0, b}) return BYTE_FAIL;
                     comps = b[2:0];
                     phase = SCAN_TAIL;
                     return BYTE_MORE;
                  end
               endcase
               field_idx = field_idx + 4'd1;
            end
            SCAN_TAIL: begin
               remaining = remaining - 16'd1;
               return (remaining == 16'd0) ? BYTE_DONE : BYTE_MORE;
            end
            default: return BYTE_FAIL;
         endcase
         return BYTE_MORE;
      endfunction

      function void note_byte(input logic [7:0] b, input logic is_last);
         byte_outcome_type   outcome;
         verdict_record_type v;
         logic [63:0]        pixels;
         if (settled) begin
            if (is_last) rearm();
            return;
         end
         outcome = parse_byte(b);
         if (outcome == BYTE_MORE && is_last) outcome = BYTE_FAIL;
         if (outcome == BYTE_MORE) return;
         v = '0;
         if (outcome == BYTE_DONE) begin
            pixels = {48'd0, width} * {48'd0, height};
            v.found = 1'b1;
            v.progressive = progressive_marker(marker);
            v.width = width;
            v.height = height;
            v.precision = precision;
            v.components = comps;
            v.fits = precision == PRECISION_RGB && budget != 64'd0 &&
                     pixels <= budget / BYTES_PER_PIXEL;
         end
         due_verdicts.push_back(v);
         settled = 1'b1;
         if (is_last) rearm();
      endfunction

      function void check_verdict(input verdict_record_type got);
         verdict_record_type want;
         if (due_verdicts.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("unexpected verdict: found=%0d w=%0d h=%0d prec=%0d comp=%0d",
                        got.found, got.width, got.height, got.precision, got.components);
            return;
         end
         want = due_verdicts.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("verdict mismatch, expected: found=%0d prog=%0d w=%0d h=%0d prec=%0d comp=%0d fits=%0d",
                        want.found, want.progressive, want.width, want.height,
                        want.precision, want.components, want.fits);
               $display("                  actual:   found=%0d prog=%0d w=%0d h=%0d prec=%0d comp=%0d fits=%0d",
                        got.found, got.progressive, got.width, got.height,
                        got.precision, got.components, got.fits);
            end
         end
      endfunction
   endclass

endpackage

### tb/tb_jpeg_frame_header_scanner_unit.sv
// Testbench top: drives JPEG byte streams into the frame header scanner and checks verdicts.
module tb_jpeg_frame_header_scanner_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import jfhs_pkg::*;
   import frame_verdict_check_pkg::*;

   localparam int unsigned RESET_CYCLES  = 9;
   localparam int unsigned IDLE_PERCENT  = 27;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned PHASE_BYTES   = 200;
   localparam int unsigned BUDGET_PHASES = 6;
   localparam int unsigned CYCLE_LIMIT   = 2000000;

   localparam logic [7:0] MARK_NULL       = 8'h00;
   localparam logic [7:0] MARK_DHT        = 8'hC4;
   localparam logic [7:0] MARK_APP0       = 8'hE0;
   localparam logic [7:0] SOF_BASELINE    = 8'hC0;
   localparam logic [7:0] SOF_EXTENDED    = 8'hC1;
   localparam logic [7:0] SOF_PROGRESSIVE = 8'hC2;
   localparam logic [7:0] SOF_LOSSLESS    = 8'hC3;
   localparam logic [7:0] SOF_DIFF_PROG   = 8'hC6;
   localparam logic [7:0] SOF_DIFF_LOSSLESS_ARITH = 8'hCF;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_found;
   logic        rsp_progressive;
   logic [15:0] rsp_image_width;
   logic [15:0] rsp_image_height;
   logic [7:0]  rsp_sample_precision;
   logic [2:0]  rsp_component_count;
   logic        rsp_fits_budget;
   logic        csr_write_enable = 1'b0;
   logic [63:0] csr_write_data = '0;

   bit          idle_on = 1'b1;
   int unsigned cycle_count = 0;
   logic [7:0]  file_image[$];
   verdict_scoreboard sb;

   jpeg_frame_header_scanner_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_last_byte        (req_last_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_found            (rsp_found),
      .rsp_progressive      (rsp_progressive),
      .rsp_image_width      (rsp_image_width),
      .rsp_image_height     (rsp_image_height),
      .rsp_sample_precision (rsp_sample_precision),
      .rsp_component_count  (rsp_component_count),
      .rsp_fits_budget      (rsp_fits_budget),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) sb.budget = csr_write_data;
         if (req_valid && !req_stall) sb.note_byte(req_data_byte, req_last_byte);
         if (rsp_valid && !rsp_stall)
            sb.check_verdict({rsp_found, rsp_progressive, rsp_image_width, rsp_image_height,
                              rsp_sample_precision, rsp_component_count, rsp_fits_budget});
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic is_last);
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= is_last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_file();
      for (int i = 0; i < file_image.size(); i++) begin
         send_byte(file_image[i], i == file_image.size() - 1);
      end
   endtask

   task automatic finish_phase();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.due_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_budget(input logic [63:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic void push_random(input int unsigned count);
      repeat (count) file_image.push_back(8'($urandom_range(255)));
   endfunction

   function automatic void open_file();
      file_image.delete();
      file_image.push_back(MARK_PREFIX);
      file_image.push_back(MARK_SOI);
   endfunction

   function automatic void add_marker(input logic [7:0] code);
      file_image.push_back(MARK_PREFIX);
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(1, 2)) file_image.push_back(MARK_PREFIX);
      file_image.push_back(code);
   endfunction

   function automatic void add_segment(input logic [7:0] code, input logic [15:0] len);
      int body_bytes;
      body_bytes = len;
      add_marker(code);
      file_image.push_back(len[15:8]);
      file_image.push_back(len[7:0]);
      for (int i = 0; i < body_bytes - 2; i++) file_image.push_back(8'($urandom_range(255)));
   endfunction

   function automatic void add_frame(input logic [7:0] code, input logic [15:0] len,
                                     input logic [7:0] prec, input logic [15:0] h,
                                     input logic [15:0] w, input logic [7:0] n);
      int body_bytes;
      body_bytes = len;
      add_marker(code);
      file_image.push_back(len[15:8]);
      file_image.push_back(len[7:0]);
      file_image.push_back(prec);
      file_image.push_back(h[15:8]);
      file_image.push_back(h[7:0]);
      file_image.push_back(w[15:8]);
      file_image.push_back(w[7:0]);
      file_image.push_back(n);
      for (int i = 6; i < body_bytes - 2; i++) file_image.push_back(8'($urandom_range(255)));
   endfunction

   function automatic logic [7:0] pick_plain_code();
      logic [7:0] m;
      do begin
         m = 8'($urandom_range(255));
      end while (m == MARK_PREFIX || m == MARK_EOI || m == MARK_SOS || m == MARK_TEM ||
                 (m >= MARK_RST0 && m <= MARK_RST7) || sof_marker(m));
      return m;
   endfunction

   function automatic logic [7:0] pick_sof();
      logic [7:0] m;
      do begin
         m = 8'($urandom_range(255));
      end while (!sof_marker(m));
      return m;
   endfunction

   function automatic logic [15:0] pick_dim();
      logic [15:0] d;
      case ($urandom_range(9))
         0: d = 16'd1;
         1: d = 16'hFFFF;
         2: d = 16'd64;
         3, 4, 5: d = 16'($urandom_range(1, 64));
         default: d = 16'($urandom_range(1, 65535));
      endcase
      return d;
   endfunction

   function automatic void add_preamble(input int unsigned count);
      logic [15:0] seg_len;
      repeat (count) begin
         if ($urandom_range(3) == 0) begin
            add_marker(($urandom_range(8) == 8) ? MARK_TEM :
                       MARK_RST0 + 8'($urandom_range(7)));
         end else begin
            seg_len = 16'(($urandom_range(19) == 0) ? $urandom_range(2, 300) :
                          $urandom_range(2, 12));
            add_segment(pick_plain_code(), seg_len);
         end
      end
   endfunction

   function automatic void build_good(input logic [15:0] w, input logic [15:0] h);
      logic [7:0] n;
      logic [7:0] prec;
      n = 8'($urandom_range(1, 4));
      prec = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : PRECISION_RGB;
      open_file();
      add_preamble($urandom_range(3));
      add_frame(pick_sof(), FRAME_LEN_MIN + COMP_SPEC_BYTES * n, prec, h, w, n);
      if ($urandom_range(1)) push_random($urandom_range(1, 6));
   endfunction

   function automatic void build_bad_frame();
      logic [7:0]  n;
      logic [15:0] len;
      logic [15:0] w;
      logic [15:0] h;
      n = 8'($urandom_range(7));
      w = ($urandom_range(3) == 0) ? 16'd0 : pick_dim();
      h = ($urandom_range(3) == 0) ? 16'd0 : pick_dim();
      case ($urandom_range(2))
         0: len = FRAME_LEN_MIN + COMP_SPEC_BYTES * n;
         1: len = FRAME_LEN_MIN + COMP_SPEC_BYTES * n + ($urandom_range(1) ? 16'd1 : -16'd1);
         default: len = 16'($urandom_range(24));
      endcase
      open_file();
      add_preamble($urandom_range(2));
      add_frame(pick_sof(), len, 8'($urandom_range(255)), h, w, n);
   endfunction

   function automatic void build_bad_segment();
      logic [7:0] b;
      open_file();
      add_preamble($urandom_range(2));
      case ($urandom_range(3))
         0: begin
            add_marker($urandom_range(1) ? pick_sof() : pick_plain_code());
            file_image.push_back(8'h00);
            file_image.push_back(8'($urandom_range(1)));
         end
         1: add_marker(MARK_EOI);
         2: add_marker(MARK_SOS);
         default: begin
            do begin
               b = 8'($urandom_range(255));
            end while (b == MARK_PREFIX);
            file_image.push_back(b);
         end
      endcase
      push_random($urandom_range(4));
   endfunction

   function automatic void build_random();
      int unsigned pick;
      int unsigned pos;
      int unsigned keep;
      pick = $urandom_range(99);
      if (pick < 65) begin
         build_good(pick_dim(), pick_dim());
      end else if (pick < 75) begin
         build_good(pick_dim(), pick_dim());
         pos = $urandom_range(file_image.size() - 1);
         if ($urandom_range(1)) file_image[pos] = 8'($urandom_range(255));
         else file_image[pos] = file_image[pos] ^ (8'd1 << $urandom_range(7));
      end else if (pick < 83) begin
         build_good(pick_dim(), pick_dim());
         keep = $urandom_range(1, file_image.size());
         while (file_image.size() > keep) file_image.delete(file_image.size() - 1);
      end else if (pick < 90) begin
         build_bad_frame();
      end else if (pick < 95) begin
         build_bad_segment();
      end else begin
         if ($urandom_range(1)) open_file();
         else file_image.delete();
         push_random($urandom_range(1, 16));
      end
   endfunction

   task automatic run_directed();
      file_image.delete();
      file_image.push_back(MARK_NULL);
      send_file();
      file_image.delete();
      file_image.push_back(MARK_PREFIX);
      file_image.push_back(MARK_NULL);
      send_file();
      open_file();
      send_file();
      open_file();
      file_image.push_back(MARK_NULL);
      send_file();
      open_file();
      repeat (3) file_image.push_back(MARK_PREFIX);
      file_image.push_back(MARK_EOI);
      send_file();
      open_file();
      add_marker(MARK_SOS);
      send_file();
      // standalone markers, then a frame exactly at the reset budget
      open_file();
      add_marker(MARK_RST0);
      add_marker(MARK_RST7);
      add_marker(MARK_TEM);
      add_frame(SOF_BASELINE, 16'd17, PRECISION_RGB, 16'd8192, 16'd8192, 8'd3);
      send_file();
      open_file();
      add_segment(MARK_NULL, 16'd1);
      send_file();
      // verdict before the final byte, one pixel row over budget
      open_file();
      add_segment(MARK_NULL, 16'd2);
      add_segment(MARK_DHT, 16'd4);
      add_frame(SOF_PROGRESSIVE, 16'd11, PRECISION_RGB, 16'd8193, 16'd8192, 8'd1);
      push_random(3);
      send_file();
      open_file();
      add_frame(SOF_BASELINE, 16'd7, PRECISION_RGB, 16'd1, 16'd1, 8'd1);
      send_file();
      open_file();
      add_frame(SOF_EXTENDED, 16'd11, PRECISION_RGB, 16'd1, 16'd0, 8'd1);
      send_file();
      open_file();
      add_frame(SOF_EXTENDED, 16'd11, PRECISION_RGB, 16'd0, 16'd1, 8'd1);
      send_file();
      open_file();
      add_frame(SOF_BASELINE, 16'd8, PRECISION_RGB, 16'd2, 16'd2, 8'd0);
      send_file();
      open_file();
      add_frame(SOF_BASELINE, 16'd23, PRECISION_RGB, 16'd2, 16'd2, 8'd5);
      send_file();
      open_file();
      add_frame(SOF_BASELINE, 16'd13, PRECISION_RGB, 16'd2, 16'd2, 8'd2);
      send_file();
      open_file();
      add_frame(SOF_DIFF_LOSSLESS_ARITH, 16'd20, 8'd12, 16'hFFFF, 16'hFFFF, 8'd4);
      send_file();
      // segment with a nonzero length high byte
      open_file();
      add_segment(MARK_APP0, 16'd258);
      add_frame(SOF_DIFF_PROG, 16'd14, PRECISION_RGB, 16'd1, 16'd1, 8'd2);
      send_file();
      open_file();
      add_segment(MARK_APP0, 16'd16);
      repeat (5) file_image.delete(file_image.size() - 1);
      send_file();
      open_file();
      add_frame(SOF_LOSSLESS, 16'd11, 8'd16, 16'd1, 16'd1, 8'd1);
      send_file();
   endtask

   initial begin
      logic [63:0] budgets[BUDGET_PHASES];
      int unsigned sent;
      sb = new();
      budgets[0] = 64'd0;
      budgets[1] = {64{1'b1}};
      budgets[2] = 64'd64 * 64'd64 * BYTES_PER_PIXEL;
      budgets[3] = 64'd64 * 64'd64 * BYTES_PER_PIXEL - 64'd1;
      budgets[4] = {$urandom, $urandom} >> $urandom_range(40);
      budgets[5] = MAX_IMAGE_BYTES_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int p = 0; p < BUDGET_PHASES; p++) begin
         finish_phase();
         write_budget(budgets[p]);
         idle_on <= (p != 1);
         build_good(16'hFFFF, 16'hFFFF);
         send_file();
         sent = 0;
         while (sent < PHASE_BYTES) begin
            build_random();
            sent += file_image.size();
            send_file();
         end
      end
      finish_phase();
      if (sb.failures == 0 && sb.due_verdicts.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/jfhs_pkg.sv
hw/rtl/jfhs_parser.sv
hw/rtl/jfhs_budget.sv
hw/rtl/jpeg_frame_header_scanner_unit.sv
tb/frame_verdict_check_pkg.sv
tb/tb_jpeg_frame_header_scanner_unit.sv
